// ----- src/csr_matrix_entry_accumulator_assert.svh -----
// assertion macros for the csr matrix entry accumulator
`ifndef CSR_MATRIX_ENTRY_ACCUMULATOR_ASSERT_SVH
`define CSR_MATRIX_ENTRY_ACCUMULATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CMEA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define CMEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/cmea_pkg.sv -----
//------------------------------------------------------------------------------
// cmea_pkg
// types and constants shared by the csr matrix entry accumulator
//------------------------------------------------------------------------------
`default_nettype none

package cmea_pkg;

    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned ROW_W   = 11;
    localparam int unsigned COL_W   = 11;
    localparam int unsigned SLOT_W  = 14;
    localparam int unsigned START_W = 15;
    localparam int unsigned VAL_W   = 48;

    localparam logic [TYPE_W-1:0] REQ_LOAD_START = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD_COL   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_LOAD_VAL   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_ACCUM      = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READ       = 3'd4;

    // request word as classified by the front end
    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [SLOT_W-1:0]  slot;
        logic [START_W-1:0] row_start;
        logic [VAL_W-1:0]   amount;
        logic               row_ok;
        logic               slot_ok;
    } t_req;

endpackage

`default_nettype wire

// ----- src/csr_matrix_entry_accumulator.sv -----
// loads and rejects go straight to output; reads pass the value read and add states
// accumulates read the row pointers, scan the row, and read and add on a hit
// one item is in flight in the back end; a two-word queue decouples intake
// the row scan compares one column entry at a time from the column memory port
// reset i_rst_n is synchronous, active low, and clears control state only
// table contents are undefined after reset until written
//------------------------------------------------------------------------------
// csr_matrix_entry_accumulator
// csr sparse matrix store with saturating scatter-add
//------------------------------------------------------------------------------
`default_nettype none

module csr_matrix_entry_accumulator #(
    parameter int unsigned MAX_ROWS     = 1024,
    parameter int unsigned MAX_NONZEROS = 16384
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [cmea_pkg::TYPE_W-1:0]       i_req_type,
    input  wire logic [cmea_pkg::ROW_W-1:0]        i_row,
    input  wire logic [cmea_pkg::COL_W-1:0]        i_column,
    input  wire logic [cmea_pkg::SLOT_W-1:0]       i_slot,
    input  wire logic [cmea_pkg::START_W-1:0]      i_row_start,
    input  wire logic signed [cmea_pkg::VAL_W-1:0] i_amount,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_status,
    output logic [cmea_pkg::SLOT_W-1:0]            o_found_slot,
    output logic signed [cmea_pkg::VAL_W-1:0]      o_stored_value,
    output logic                                   o_saturated
);

    logic           w_q_valid, w_q_pop;
    cmea_pkg::t_req w_q_req;

    cmea_front #(.MAX_ROWS(MAX_ROWS), .MAX_NONZEROS(MAX_NONZEROS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_req_type, .i_row, .i_column, .i_slot, .i_row_start, .i_amount,
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_req(w_q_req)
    );

    cmea_back #(.MAX_ROWS(MAX_ROWS), .MAX_NONZEROS(MAX_NONZEROS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_req(w_q_req),
        .o_valid, .i_stall, .o_status, .o_found_slot, .o_stored_value, .o_saturated
    );

endmodule

`default_nettype wire

// ----- src/cmea_front.sv -----
//------------------------------------------------------------------------------
// cmea_front
// accepts request words, checks ranges and pushes them into a short queue
//------------------------------------------------------------------------------
`default_nettype none

module cmea_front #(
    parameter int unsigned MAX_ROWS     = 1024,
    parameter int unsigned MAX_NONZEROS = 16384
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [cmea_pkg::TYPE_W-1:0]     i_req_type,
    input  wire logic [cmea_pkg::ROW_W-1:0]      i_row,
    input  wire logic [cmea_pkg::COL_W-1:0]      i_column,
    input  wire logic [cmea_pkg::SLOT_W-1:0]     i_slot,
    input  wire logic [cmea_pkg::START_W-1:0]    i_row_start,
    input  wire logic signed [cmea_pkg::VAL_W-1:0] i_amount,
    output logic                                 o_q_valid,
    input  wire logic                            i_q_pop,
    output cmea_pkg::t_req                       o_q_req
);

    localparam int unsigned DEPTH = 2;

    cmea_pkg::t_req r_q [DEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    cmea_pkg::t_req w_req;
    logic           w_push, w_pop;

    always_comb begin
        w_req.req_type  = i_req_type;
        w_req.row       = i_row;
        w_req.column    = i_column;
        w_req.slot      = i_slot;
        w_req.row_start = i_row_start;
        w_req.amount    = i_amount;
        w_req.row_ok    = (32'(i_row) <= MAX_ROWS);
        w_req.slot_ok   = (32'(i_slot) < MAX_NONZEROS);
    end

    assign o_stall   = (r_cnt == 2'(DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ----- src/cmea_back.sv -----
//------------------------------------------------------------------------------
// cmea_back
// executes queued requests against the pointer, column and value memories
//------------------------------------------------------------------------------
`default_nettype none

`include "csr_matrix_entry_accumulator_assert.svh"

module cmea_back #(
    parameter int unsigned MAX_ROWS     = 1024,
    parameter int unsigned MAX_NONZEROS = 16384
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    output logic                                   o_q_pop,
    input  wire cmea_pkg::t_req                    i_q_req,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_status,
    output logic [cmea_pkg::SLOT_W-1:0]            o_found_slot,
    output logic signed [cmea_pkg::VAL_W-1:0]      o_stored_value,
    output logic                                   o_saturated
);

    localparam int unsigned PW = (MAX_ROWS + 1 > 1) ? $clog2(MAX_ROWS + 1) : 1;
    localparam int unsigned NW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int unsigned SW = cmea_pkg::START_W;
    localparam int unsigned VW = cmea_pkg::VAL_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PTR0  = 9'b000000010,
        S_PTR1  = 9'b000000100,
        S_PTR2  = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_CMP   = 9'b000100000,
        S_VRD   = 9'b001000000,
        S_ADD   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    logic [SW-1:0]          r_ptr_mem [MAX_ROWS + 1];
    logic [cmea_pkg::COL_W-1:0] r_col_mem [MAX_NONZEROS];
    logic [VW-1:0]          r_val_mem [MAX_NONZEROS];

    t_state                 r_state;
    cmea_pkg::t_req         r_req;
    logic [SW-1:0]          r_ptr_rd, r_first;
    logic [SW:0]            r_n, r_last;
    logic [cmea_pkg::COL_W-1:0] r_col_rd;
    logic [VW-1:0]          r_val_rd;
    logic                   r_read_op;

    logic [PW-1:0]          w_ptr_addr;
    logic                   w_ptr_rd_en;
    logic [NW-1:0]          w_n_addr;

    // take a new word only once the previous result word has left
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && (!o_valid || !i_stall);
    assign w_n_addr = r_n[NW-1:0];

    // pointer memory port
    always_comb begin
        w_ptr_addr  = PW'(r_req.row);
        w_ptr_rd_en = 1'b0;
        case (r_state)
            S_PTR0:  begin w_ptr_addr = PW'(r_req.row - 1'b1); w_ptr_rd_en = 1'b1; end
            S_PTR1:  begin w_ptr_addr = PW'(r_req.row);        w_ptr_rd_en = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_req.req_type == cmea_pkg::REQ_LOAD_START
            && i_q_req.row_ok) begin
            r_ptr_mem[PW'(i_q_req.row)] <= i_q_req.row_start;
        end
        if (w_ptr_rd_en) r_ptr_rd <= r_ptr_mem[w_ptr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_req.req_type == cmea_pkg::REQ_LOAD_COL
            && i_q_req.slot_ok) begin
            r_col_mem[NW'(i_q_req.slot)] <= i_q_req.column;
        end
        r_col_rd <= r_col_mem[w_n_addr];
    end

    // value memory: load and accumulate writes share one port
    logic          w_val_we;
    logic [NW-1:0] w_val_wa;
    logic [VW-1:0] w_val_wd;
    logic [VW:0]   w_sum;
    logic          w_pos_ov, w_neg_ov;
    logic [VW-1:0] w_sat_val;

    assign w_sum    = {r_val_rd[VW-1], r_val_rd} + {r_req.amount[VW-1], r_req.amount};
    assign w_pos_ov = (w_sum[VW:VW-1] == 2'b01);
    assign w_neg_ov = (w_sum[VW:VW-1] == 2'b10);
    assign w_sat_val = w_pos_ov ? {1'b0, {(VW-1){1'b1}}} :
                       w_neg_ov ? {1'b1, {(VW-1){1'b0}}} : w_sum[VW-1:0];

    always_comb begin
        w_val_we = 1'b0;
        w_val_wa = NW'(i_q_req.slot);
        w_val_wd = i_q_req.amount;
        if (o_q_pop && i_q_req.req_type == cmea_pkg::REQ_LOAD_VAL
            && i_q_req.slot_ok) begin
            w_val_we = 1'b1;
        end else if (r_state == S_ADD && !r_read_op) begin
            w_val_we = 1'b1;
            w_val_wa = w_n_addr;
            w_val_wd = w_sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) r_val_mem[w_val_wa] <= w_val_wd;
        if (r_state == S_VRD) r_val_rd <= r_val_mem[w_n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_req     <= i_q_req;
                        r_read_op <= 1'b0;
                        case (i_q_req.req_type)
                            cmea_pkg::REQ_ACCUM: begin
                                if (i_q_req.row != '0 && i_q_req.row_ok) begin
                                    r_state <= S_PTR0;
                                end else begin
                                    o_status <= 1'b1; o_found_slot <= '0;
                                    o_stored_value <= '0; o_saturated <= 1'b0;
                                    r_state <= S_OUT;
                                end
                            end
                            cmea_pkg::REQ_READ: begin
                                if (i_q_req.slot_ok) begin
                                    r_n       <= (SW+1)'(i_q_req.slot);
                                    r_read_op <= 1'b1;
                                    r_state   <= S_VRD;
                                end else begin
                                    o_status <= 1'b1; o_found_slot <= '0;
                                    o_stored_value <= '0; o_saturated <= 1'b0;
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                o_status <= 1'b0; o_found_slot <= '0;
                                o_stored_value <= '0; o_saturated <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_PTR0: r_state <= S_PTR1;
                S_PTR1: begin
                    r_first <= (r_ptr_rd == '0) ? '0 : r_ptr_rd - 1'b1;
                    r_state <= S_PTR2;
                end
                S_PTR2: begin
                    // clip the exclusive end to the store size
                    if (r_ptr_rd == '0) begin
                        r_last <= '0;
                    end else if (32'(r_ptr_rd) - 1 > MAX_NONZEROS) begin
                        r_last <= (SW+1)'(MAX_NONZEROS);
                    end else begin
                        r_last <= (SW+1)'(r_ptr_rd - 1'b1);
                    end
                    r_n     <= (SW+1)'(r_first);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_n >= r_last) begin
                        o_status <= 1'b1; o_found_slot <= '0;
                        o_stored_value <= '0; o_saturated <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_col_rd == r_req.column) begin
                        r_state <= S_VRD;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_VRD: r_state <= S_ADD;
                S_ADD: begin
                    o_status     <= 1'b0;
                    o_found_slot <= cmea_pkg::SLOT_W'(r_n);
                    if (r_read_op) begin
                        o_stored_value <= r_val_rd;
                        o_saturated    <= 1'b0;
                    end else begin
                        o_stored_value <= w_sat_val;
                        o_saturated    <= w_pos_ov || w_neg_ov;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CMEA_ASSERT_IMPL(a_pop_only_idle, i_clk, i_rst_n, o_q_pop, r_state == S_IDLE)
    `CMEA_ASSERT_NEXT(a_held_out, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_stored_value) && $stable(o_status))
    `CMEA_ASSERT_IMPL(a_sat_on_hit, i_clk, i_rst_n, o_valid && o_saturated, !o_status)
    // a read must never write back into the value store
    `CMEA_ASSERT_IMPL(a_read_no_write, i_clk, i_rst_n, r_state == S_ADD && r_read_op, !w_val_we)

endmodule

`default_nettype wire

// ----- tb/sv/tb_csr_matrix_entry_accumulator.sv -----
//------------------------------------------------------------------------------
// tb_csr_matrix_entry_accumulator
// self-checking bench: loads a sparse matrix in row-compressed form, then
// scatter-adds, reads and reloads through the block and compares every result
// word against a local model of the tables, under varying sender and receiver
// idling and one long receiver hold-off
//------------------------------------------------------------------------------
`default_nettype none

module tb_csr_matrix_entry_accumulator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROWS      = 1024;
    localparam int unsigned NONZEROS  = 16384;
    localparam int unsigned N_ITEMS   = 1650;
    localparam int unsigned LIMIT     = 3000000;
    localparam int unsigned HOLD_LEN  = 400;

    // request codes the block ignores
    localparam logic [cmea_pkg::TYPE_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [cmea_pkg::TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic signed [cmea_pkg::VAL_W-1:0] VMAX = {1'b0, {(cmea_pkg::VAL_W-1){1'b1}}};
    localparam logic signed [cmea_pkg::VAL_W-1:0] VMIN = {1'b1, {(cmea_pkg::VAL_W-1){1'b0}}};

    typedef struct {
        logic [cmea_pkg::TYPE_W-1:0]        kind;
        logic [cmea_pkg::ROW_W-1:0]         row;
        logic [cmea_pkg::COL_W-1:0]         col;
        logic [cmea_pkg::SLOT_W-1:0]        slot;
        logic [cmea_pkg::START_W-1:0]       start;
        logic signed [cmea_pkg::VAL_W-1:0]  amt;
    } t_word;

    typedef struct {
        logic                               status;
        logic [cmea_pkg::SLOT_W-1:0]        slot;
        logic signed [cmea_pkg::VAL_W-1:0]  val;
        logic                               sat;
    } t_result;

    typedef struct {
        t_word   w;
        bit      typed;
        t_result res;
    } t_step;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [cmea_pkg::TYPE_W-1:0]        i_req_type = '0;
    logic [cmea_pkg::ROW_W-1:0]         i_row = '0;
    logic [cmea_pkg::COL_W-1:0]         i_column = '0;
    logic [cmea_pkg::SLOT_W-1:0]        i_slot = '0;
    logic [cmea_pkg::START_W-1:0]       i_row_start = '0;
    logic signed [cmea_pkg::VAL_W-1:0]  i_amount = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic                               o_status;
    logic [cmea_pkg::SLOT_W-1:0]        o_found_slot;
    logic signed [cmea_pkg::VAL_W-1:0]  o_stored_value;
    logic                               o_saturated;

    csr_matrix_entry_accumulator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_slot         (i_slot),
        .i_row_start    (i_row_start),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_found_slot   (o_found_slot),
        .o_stored_value (o_stored_value),
        .o_saturated    (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // model of the matrix tables, with written flags
    logic [cmea_pkg::START_W-1:0]       row_ptr [0:ROWS];
    logic [cmea_pkg::COL_W-1:0]         col_idx [0:NONZEROS-1];
    logic signed [cmea_pkg::VAL_W-1:0]  values  [0:NONZEROS-1];
    bit                                 ptr_set [0:ROWS];
    bit                                 col_set [0:NONZEROS-1];
    bit                                 val_set [0:NONZEROS-1];

    t_result     pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_go = 1'b0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // apply one accepted word to the table model and return its result word
    function automatic t_result scatter_add(input t_word w);
        t_result r = '{1'b0, '0, '0, 1'b0};
        int unsigned first, last, n;
        logic signed [cmea_pkg::VAL_W:0] sum;
        case (w.kind)
            cmea_pkg::REQ_LOAD_START: if (w.row <= ROWS) begin
                row_ptr[w.row] = w.start;
                ptr_set[w.row] = 1'b1;
            end
            cmea_pkg::REQ_LOAD_COL: begin
                col_idx[w.slot] = w.col;
                col_set[w.slot] = 1'b1;
            end
            cmea_pkg::REQ_LOAD_VAL: begin
                values[w.slot] = w.amt;
                val_set[w.slot] = 1'b1;
            end
            cmea_pkg::REQ_ACCUM: begin
                r.status = 1'b1;
                if (w.row >= 1 && w.row <= ROWS) begin
                    first = (row_ptr[w.row-1] == 0) ? 0 : row_ptr[w.row-1] - 1;
                    last  = (row_ptr[w.row] == 0) ? 0 : row_ptr[w.row] - 1;
                    if (last > NONZEROS) last = NONZEROS;
                    for (n = first; n < last; n++) begin
                        if (col_idx[n] == w.col) begin
                            sum = {values[n][cmea_pkg::VAL_W-1], values[n]}
                                + {w.amt[cmea_pkg::VAL_W-1], w.amt};
                            r.status = 1'b0;
                            r.slot = cmea_pkg::SLOT_W'(n);
                            if (sum > $signed({1'b0, VMAX})) begin
                                r.val = VMAX;
                                r.sat = 1'b1;
                            end else if (sum < $signed({1'b1, VMIN})) begin
                                r.val = VMIN;
                                r.sat = 1'b1;
                            end else begin
                                r.val = sum[cmea_pkg::VAL_W-1:0];
                            end
                            values[n] = r.val;
                            break;
                        end
                    end
                end
            end
            cmea_pkg::REQ_READ: begin
                r.slot = w.slot;
                r.val = values[w.slot];
            end
            default: ;
        endcase
        return r;
    endfunction

    // an accumulate may only touch entries that were written
    function automatic bit accum_safe(input logic [cmea_pkg::ROW_W-1:0] row,
                                      input logic [cmea_pkg::COL_W-1:0] col);
        int unsigned first, last, n;
        if (row == 0 || row > ROWS) return 1'b1;
        if (!ptr_set[row-1] || !ptr_set[row]) return 1'b0;
        first = (row_ptr[row-1] == 0) ? 0 : row_ptr[row-1] - 1;
        last  = (row_ptr[row] == 0) ? 0 : row_ptr[row] - 1;
        if (last > NONZEROS) last = NONZEROS;
        for (n = first; n < last; n++) begin
            if (!col_set[n]) return 1'b0;
            if (col_idx[n] == col) return val_set[n];
        end
        return 1'b1;
    endfunction

    function automatic logic signed [cmea_pkg::VAL_W-1:0] rand_amount();
        case ($urandom_range(9))
            0: return VMAX;
            1: return VMIN;
            2: return $signed(cmea_pkg::VAL_W'($urandom_range(255))) - 128;
            default: return cmea_pkg::VAL_W'({$urandom, $urandom});
        endcase
    endfunction

    // drive one word and wait for it to be taken, then predict and maybe idle
    task automatic send(input t_step s);
        t_result r;
        i_valid     <= 1'b1;
        i_req_type  <= s.w.kind;
        i_row       <= s.w.row;
        i_column    <= s.w.col;
        i_slot      <= s.w.slot;
        i_row_start <= s.w.start;
        i_amount    <= s.w.amt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = scatter_add(s.w);
        pending_results = {pending_results, (s.typed ? s.res : r)};
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_step mk(input logic [cmea_pkg::TYPE_W-1:0] kind, input int row,
                                 input int col, input int slot, input int start,
                                 input logic signed [cmea_pkg::VAL_W-1:0] amt);
        t_step s;
        s.w = '{kind, cmea_pkg::ROW_W'(row), cmea_pkg::COL_W'(col), cmea_pkg::SLOT_W'(slot),
                cmea_pkg::START_W'(start), amt};
        s.typed = 1'b0;
        s.res = '{1'b0, '0, '0, 1'b0};
        return s;
    endfunction

    function automatic t_step typed(input t_step s, input logic st, input int slot,
                                    input logic signed [cmea_pkg::VAL_W-1:0] val,
                                    input logic sat);
        s.typed = 1'b1;
        s.res = '{st, cmea_pkg::SLOT_W'(slot), val, sat};
        return s;
    endfunction

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        static int unsigned hold_left = 0;
        if (hold_go) begin
            hold_left = HOLD_LEN;
            hold_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status)
                    report($sformatf("status %0b, expected %0b", o_status, e.status));
                if (o_found_slot !== e.slot)
                    report($sformatf("slot %0d, expected %0d", o_found_slot, e.slot));
                if (o_stored_value !== e.val)
                    report($sformatf("value %0d, expected %0d", o_stored_value, e.val));
                if (o_saturated !== e.sat)
                    report($sformatf("saturated %0b, expected %0b", o_saturated, e.sat));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_step       directed[$];
        t_step       s;
        int unsigned sent;
        int unsigned cursor;
        int unsigned phase;
        int unsigned r, len, k, tries;
        int unsigned built_rows[$];
        int unsigned val_slots[$];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // row 1 spans slots 0..1 with a zero row start, row 2 empty,
        // row 4 runs past the end of the store, row 5 inverted
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_VAL, 0, 0, 0, 0, VMAX), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_VAL, 0, 0, 1, 0, VMIN), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_COL, 0, 5, 0, 0, 0), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_COL, 0, 1024, 1, 0, 0), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_START, 0, 0, 0, 0, 0), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_START, 1, 0, 0, 3, 0), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 1, 5, 0, 0, 1), 0, 0, VMAX, 1)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 1, 1024, 0, 0, -1), 0, 1, VMIN, 1)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 1, 7, 0, 0, 3), 1, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 0, 5, 0, 0, 3), 1, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 2047, 1, 0, 0, 3), 1, 0, 0, 0)};
        directed = {directed,
                    typed(mk(cmea_pkg::REQ_LOAD_START, 1025, 0, 0, 32767, 0), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_LOAD_START, 2, 0, 0, 3, 0), 0, 0, 0, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 2, 5, 0, 0, 3), 1, 0, 0, 0)};
        directed = {directed, mk(cmea_pkg::REQ_LOAD_COL, 0, 9, 2, 0, 0)};
        directed = {directed, mk(cmea_pkg::REQ_LOAD_VAL, 0, 0, 2, 0, 0)};
        directed = {directed, mk(cmea_pkg::REQ_LOAD_START, 3, 0, 0, 3, 0)};
        directed = {directed, mk(cmea_pkg::REQ_LOAD_START, 4, 0, 0, 32767, 0)};
        directed = {directed, mk(cmea_pkg::REQ_ACCUM, 4, 9, 0, 0, 5)};
        directed = {directed, mk(cmea_pkg::REQ_LOAD_START, 5, 0, 0, 2, 0)};
        directed = {directed, typed(mk(cmea_pkg::REQ_ACCUM, 5, 9, 0, 0, 5), 1, 0, 0, 0)};
        directed = {directed, mk(cmea_pkg::REQ_LOAD_VAL, 0, 0, 16383, 0, -1)};
        directed = {directed,
                    typed(mk(cmea_pkg::REQ_READ, 0, 0, 16383, 0, 0), 0, 16383, -1, 0)};
        directed = {directed, mk(cmea_pkg::REQ_READ, 0, 0, 0, 0, 0)};
        directed = {directed,
                    typed(mk(REQ_SPARE_HI, 2047, 2047, 16383, 32767, -1), 0, 0, 0, 0)};
        directed = {directed, typed(mk(REQ_SPARE_LO, 0, 0, 0, 0, 0), 0, 0, 0, 0)};

        foreach (directed[i]) send(directed[i]);
        val_slots = '{0, 1, 2, 16383};

        sent = 0;
        cursor = 16;
        phase = 0;
        while (sent < N_ITEMS) begin
            if (phase == 0 && sent >= 300) begin
                phase = 1;
                idle_pct = 88;
            end else if (phase == 1 && sent >= 650) begin
                phase = 2;
                idle_pct = 0;
                stall_pct = 88;
            end else if (phase == 2 && sent >= 1000) begin
                phase = 3;
                idle_pct = 29;
                stall_pct = 29;
            end else if (phase == 3 && sent >= 1300) begin
                phase = 4;
                idle_pct = 0;
                stall_pct = 0;
                hold_go = 1'b1;
            end

            if ($urandom_range(99) < 12 || built_rows.size() == 0) begin
                // build a fresh row segment for later accumulates to hit
                r = $urandom_range(6, ROWS - 1);
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                if (cursor + len >= NONZEROS - 8) cursor = 16;
                send(mk(cmea_pkg::REQ_LOAD_START, r - 1, 0, 0, cursor + 1, 0));
                send(mk(cmea_pkg::REQ_LOAD_START, r, 0, 0, cursor + 1 + len, 0));
                sent += 2;
                for (k = 0; k < len; k++) begin
                    send(mk(cmea_pkg::REQ_LOAD_COL, 0, $urandom_range(1, 40), cursor + k, 0, 0));
                    send(mk(cmea_pkg::REQ_LOAD_VAL, 0, 0, cursor + k, 0, rand_amount()));
                    val_slots = {val_slots, cursor + k};
                    sent += 2;
                end
                cursor += len;
                built_rows = {built_rows, r};
                continue;
            end

            case ($urandom_range(19))
                0, 1: s = mk(cmea_pkg::REQ_LOAD_COL, 0, $urandom_range(2047),
                             $urandom_range(16383), 0, 0);
                2: s = mk(cmea_pkg::REQ_LOAD_VAL, 0, 0, $urandom_range(16383), 0,
                          rand_amount());
                3: s = mk(cmea_pkg::REQ_LOAD_START, $urandom_range(1025, 2047), 0, 0,
                          $urandom_range(32767), 0);
                4: s = mk(cmea_pkg::TYPE_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                          $urandom_range(2047), $urandom_range(2047), $urandom_range(16383),
                          $urandom_range(32767), rand_amount());
                5, 6, 7: s = mk(cmea_pkg::REQ_READ, 0, 0,
                                val_slots[$urandom_range(val_slots.size() - 1)], 0,
                                rand_amount());
                8: s = mk(cmea_pkg::REQ_ACCUM,
                          ($urandom_range(1)) ? 0 : $urandom_range(1025, 2047),
                          $urandom_range(2047), 0, 0, rand_amount());
                default: begin
                    s = mk(cmea_pkg::REQ_ACCUM, 0, 0, 0, 0, rand_amount());
                    for (tries = 0; tries < 4; tries++) begin
                        s.w.row = cmea_pkg::ROW_W'(
                            built_rows[$urandom_range(built_rows.size() - 1)]);
                        s.w.col = ($urandom_range(7) == 0)
                                ? cmea_pkg::COL_W'($urandom_range(2047))
                                : cmea_pkg::COL_W'($urandom_range(1, 40));
                        if (accum_safe(s.w.row, s.w.col)) break;
                    end
                    if (!accum_safe(s.w.row, s.w.col))
                        s = mk(cmea_pkg::REQ_READ, 0, 0, 0, 0, 0);
                end
            endcase
            if (s.w.kind == cmea_pkg::REQ_LOAD_VAL) val_slots = {val_slots, int'(s.w.slot)};
            send(s);
            if (s.w.kind <= cmea_pkg::REQ_READ) sent++;
        end

        i_valid <= 1'b0;
        idle_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
